@@ hw/rtl/multicast_hash_filter_builder_core_defines.svh @@
// Assertion macros used by the checker file.
`ifndef MULTICAST_HASH_FILTER_BUILDER_CORE_DEFINES_SVH
`define MULTICAST_HASH_FILTER_BUILDER_CORE_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define MHFB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MHFB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hw/rtl/mhfb_pkg.sv @@
package mhfb_pkg;

    localparam int ADDR_W      = 48;
    localparam int IDX_W       = 6;
    localparam int FILTER_W    = 64;
    localparam int WORD_W      = 16;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 1;
    localparam int CRC_TOP     = 26;

    localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
    localparam logic [31:0] CRC_INIT = 32'hffff_ffff;

    localparam logic [CFG_INDEX_W-1:0] REG_ALLMULTI = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PROMISC  = 1'b1;

    localparam logic KIND_START = 1'b0;

    typedef struct packed {
        logic             start;
        logic             is_range;
        logic             allmulti_req;
        logic [IDX_W-1:0] idx;
    } accum_cmd_t;

    function automatic logic [31:0] crc48(input logic [ADDR_W-1:0] addr,
                                          input logic [31:0] init);
        logic [31:0] crc;
        logic        fb;
        crc = init;
        for (int k = 0; k < 6; k++) begin
            for (int b = 0; b < 8; b++) begin
                fb  = crc[0] ^ addr[40 - 8 * k + b];
                crc = crc >> 1;
                if (fb) begin
                    crc = crc ^ CRC_POLY;
                end
            end
        end
        return crc;
    endfunction

    // Address bits whose parity forms hash bit j (the CRC is affine in the address).
    function automatic logic [ADDR_W-1:0] hash_mask(input int j);
        logic [ADDR_W-1:0] m;
        logic [31:0]       c;
        m = '0;
        for (int p = 0; p < ADDR_W; p++) begin
            c    = crc48(ADDR_W'(1) << p, 32'd0);
            m[p] = c[CRC_TOP + j];
        end
        return m;
    endfunction

    localparam logic [31:0] CRC_ZERO = crc48('0, CRC_INIT);

endpackage

@@ hw/rtl/multicast_hash_filter_builder_core.sv @@
// Multicast hash filter builder.
// Input stream: s_tuser gives the kind of word (0 starts a new list and
// clears the filter, 1 adds an address range); s_tdata carries the low and
// high addresses of the range. Every input word yields exactly one output
// word holding the four 16-bit filter words and the two mode flags.
// Configuration: the all-multicast and promiscuous request registers are
// written through cfg_wr_en, cfg_index and cfg_wdata; the user must do so only
// while the block is idle, which the block itself does not enforce. Each output
// word is computed from the input register and loaded when that register
// advances. One word is accepted per cycle unless the output stalls: the CRC
// hash is a parity network over the address and fits between the input
// register and the output register. A full output register that is not taken
// holds its word; the input register still takes one more word, and s_tready
// falls only when both are full. Reset clears the filter, the all-multicast
// flag, both request registers and both valid flags.
module multicast_hash_filter_builder_core
    import mhfb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // addr_low[47:0], addr_high[95:48]
    input  logic                   s_tuser,   // kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // hash_word0..3[63:0], allmulti_active[64],
                                              // promisc_enable[65], zero[71:66]
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic                   allmulti_request_reg;
    logic                   promisc_request_reg;
    logic                   in_valid_reg;
    logic                   kind_reg;
    logic [ADDR_W-1:0]      addr_low_reg;
    logic [ADDR_W-1:0]      addr_high_reg;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;
    logic                   advance;
    logic [IDX_W-1:0]       hash_idx;
    accum_cmd_t             cmd;
    logic [FILTER_W-1:0]    filter_next;
    logic                   allmulti_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allmulti_request_reg <= 1'b0;
            promisc_request_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ALLMULTI: allmulti_request_reg <= cfg_wdata[0];
                REG_PROMISC:  promisc_request_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg      <= s_tuser;
            addr_low_reg  <= s_tdata[ADDR_W-1:0];
            addr_high_reg <= s_tdata[2*ADDR_W-1:ADDR_W];
        end
    end

    mhfb_hash u_hash (
        .addr (addr_low_reg),
        .idx  (hash_idx)
    );

    always_comb begin
        cmd.start        = (kind_reg == KIND_START);
        cmd.is_range     = (addr_low_reg != addr_high_reg);
        cmd.allmulti_req = allmulti_request_reg | promisc_request_reg;
        cmd.idx          = hash_idx;
    end

    mhfb_accum u_accum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (advance),
        .cmd           (cmd),
        .filter_next   (filter_next),
        .allmulti_next (allmulti_next)
    );

    always_comb begin
        out_data_next = '0;
        out_data_next[FILTER_W-1:0] = allmulti_next ? {FILTER_W{1'b1}} : filter_next;
        out_data_next[FILTER_W]     = allmulti_next;
        out_data_next[FILTER_W+1]   = promisc_request_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ hw/rtl/mhfb_hash.sv @@
module mhfb_hash
    import mhfb_pkg::*;
(
    input  logic [ADDR_W-1:0] addr,
    output logic [IDX_W-1:0]  idx
);

    for (genvar j = 0; j < IDX_W; j++) begin : g_bit
        localparam logic [ADDR_W-1:0] Mask = hash_mask(j);
        assign idx[j] = (^(addr & Mask)) ^ CRC_ZERO[CRC_TOP + j];
    end

endmodule

@@ hw/rtl/mhfb_accum.sv @@
module mhfb_accum
    import mhfb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  accum_cmd_t          cmd,
    output logic [FILTER_W-1:0] filter_next,
    output logic                allmulti_next
);

    logic [FILTER_W-1:0] filter_reg;
    logic                allmulti_reg;

    always_comb begin
        filter_next   = filter_reg;
        allmulti_next = allmulti_reg;
        if (cmd.start) begin
            filter_next   = '0;
            allmulti_next = cmd.allmulti_req;
        end else if (cmd.is_range) begin
            allmulti_next = 1'b1;
        end else begin
            filter_next = filter_reg | (FILTER_W'(1) << cmd.idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg   <= '0;
            allmulti_reg <= 1'b0;
        end else if (en) begin
            filter_reg   <= filter_next;
            allmulti_reg <= allmulti_next;
        end
    end

endmodule

@@ hw/rtl/mhfb_checker.sv @@
`include "multicast_hash_filter_builder_core_defines.svh"

module mhfb_checker
    import mhfb_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic stalled;
    logic allmulti_word;
    logic all_ones;

    assign stalled       = m_tvalid && !m_tready;
    assign allmulti_word = m_tvalid && m_tdata[FILTER_W];
    assign all_ones      = &m_tdata[FILTER_W-1:0];

    `MHFB_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "output word valid after reset")
    `MHFB_ASSERT(a_stall_hold, stalled |=> m_tvalid && $stable(m_tdata), "stalled word changed")
    `MHFB_ASSERT(a_allmulti_ones, allmulti_word |-> all_ones, "all-multicast word not all ones")
    `MHFB_ASSERT(a_input_stall, !s_tready |-> stalled, "input stalled while output free")

endmodule

bind multicast_hash_filter_builder_core mhfb_checker u_mhfb_checker (.*);
